/* hw/rtl/tls_record_deframer_unit_macros.svh */
// Assertion macros used by the record deframer back part.
`ifndef TLS_RECORD_DEFRAMER_UNIT_MACROS_SVH
`define TLS_RECORD_DEFRAMER_UNIT_MACROS_SVH

// Antecedent holds in a cycle, so the consequent must hold in the same cycle.
`define TRD_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// Antecedent holds in a cycle, so the consequent must hold in the next cycle.
`define TRD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

/* hw/rtl/trd_pkg.sv */
// Types and constants shared by the record deframer modules.
package trd_pkg;

  // Saturating byte counter and header fields.
  typedef logic [16:0] count_t;
  typedef logic [15:0] length_t;
  typedef logic [7:0]  byte_t;
  typedef logic [1:0]  cfg_index_t;

  // Header layout and counter limit.
  localparam count_t HDR_BYTES  = 17'd5;
  localparam count_t POS_LEN_HI = 17'd3;
  localparam count_t POS_LEN_LO = 17'd4;
  localparam count_t COUNT_MAX  = 17'h1FFFF;

  // Valid content types.
  localparam byte_t TYPE_LOW     = 8'd20;
  localparam byte_t TYPE_HIGH    = 8'd23;
  localparam byte_t TYPE_APPDATA = 8'd23;

  // Configuration register indexes and reset values.
  localparam cfg_index_t CFG_MAX_PLAIN  = 2'd0;
  localparam cfg_index_t CFG_MAX_CIPHER = 2'd1;
  localparam length_t MAX_PLAIN_RST  = 16'd16384;
  localparam length_t MAX_CIPHER_RST = 16'd16640;

  // Depth of the queue between the front and back parts.
  localparam int QUEUE_DEPTH = 2;

  // Final record status codes.
  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_BAD_TYPE = 2'd1,
    ST_OVERFLOW = 2'd2,
    ST_LENGTH   = 2'd3
  } status_t;

  // One classified byte as it travels from the front part to the back part.
  typedef struct packed {
    byte_t   data;
    logic    pv;
    logic    last;
    count_t  seen;
    byte_t   rtype;
    length_t dlen;
  } item_t;

endpackage

/* hw/rtl/trd_if.sv */
// Channel interfaces of the record deframer: input bytes, results and configuration.
interface trd_in_if;
  logic                valid;
  logic                ready;
  trd_pkg::byte_t      in_byte;
  logic                buffer_last;
  modport source (output valid, output in_byte, output buffer_last, input ready);
  modport sink   (input valid, input in_byte, input buffer_last, output ready);
endinterface

interface trd_out_if;
  logic                valid;
  logic                ready;
  trd_pkg::byte_t      payload_byte;
  logic                payload_valid;
  logic                record_done;
  logic [1:0]          status;
  trd_pkg::byte_t      content_type;
  trd_pkg::length_t    payload_length;
  trd_pkg::count_t     record_span;
  logic                span_complete;
  modport source (output valid, output payload_byte, output payload_valid,
                  output record_done, output status, output content_type,
                  output payload_length, output record_span, output span_complete,
                  input ready);
  modport sink   (input valid, input payload_byte, input payload_valid,
                  input record_done, input status, input content_type,
                  input payload_length, input record_span, input span_complete,
                  output ready);
endinterface

interface trd_cfg_if;
  logic                  valid;
  logic                  ready;
  trd_pkg::cfg_index_t   index;
  trd_pkg::length_t      data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

/* hw/rtl/trd_front.sv */
// Front part: accepts bytes, tracks the header and classifies each byte.
module trd_front (
  input  logic              clk,
  input  logic              rst_n,
  trd_in_if.sink            in_chan,
  input  logic              q_full,
  output logic              q_push,
  output trd_pkg::item_t    q_item
);

  trd_pkg::count_t  byte_count_r, byte_count_nxt;
  trd_pkg::byte_t   rtype_r, rtype_nxt;
  trd_pkg::length_t dlen_r, dlen_nxt;
  trd_pkg::count_t  pos;
  trd_pkg::count_t  seen;
  trd_pkg::byte_t   rtype_upd;
  trd_pkg::length_t dlen_upd;

  assign in_chan.ready = !q_full;
  assign q_push        = in_chan.valid && in_chan.ready;
  assign pos           = byte_count_r;

  // Capture header fields as their positions go by; the count saturates.
  always_comb begin
    rtype_upd = rtype_r;
    dlen_upd  = dlen_r;
    if (pos == '0) begin
      rtype_upd = in_chan.in_byte;
    end else if (pos == trd_pkg::POS_LEN_HI) begin
      dlen_upd = {in_chan.in_byte, dlen_r[7:0]};
    end else if (pos == trd_pkg::POS_LEN_LO) begin
      dlen_upd = {dlen_r[15:8], in_chan.in_byte};
    end
    seen = (pos < trd_pkg::COUNT_MAX) ? pos + 17'd1 : trd_pkg::COUNT_MAX;
  end

  // Classified transaction handed to the queue.
  always_comb begin
    q_item.data  = in_chan.in_byte;
    q_item.pv    = (pos >= trd_pkg::HDR_BYTES);
    q_item.last  = in_chan.buffer_last;
    q_item.seen  = seen;
    q_item.rtype = rtype_upd;
    q_item.dlen  = dlen_upd;
  end

  // The last byte of a buffer clears the header state for the next one.
  always_comb begin
    byte_count_nxt = byte_count_r;
    rtype_nxt      = rtype_r;
    dlen_nxt       = dlen_r;
    if (q_push) begin
      if (in_chan.buffer_last) begin
        byte_count_nxt = '0;
        rtype_nxt      = '0;
        dlen_nxt       = '0;
      end else begin
        byte_count_nxt = seen;
        rtype_nxt      = rtype_upd;
        dlen_nxt       = dlen_upd;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_count_r <= '0;
      rtype_r      <= '0;
      dlen_r       <= '0;
    end else begin
      byte_count_r <= byte_count_nxt;
      rtype_r      <= rtype_nxt;
      dlen_r       <= dlen_nxt;
    end
  end

endmodule

/* hw/rtl/trd_queue.sv */
// Short queue of classified bytes between the front and back parts.
module trd_queue #(
  parameter int DEPTH = trd_pkg::QUEUE_DEPTH
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  trd_pkg::item_t    push_item,
  output logic              full,
  input  logic              pop,
  output logic              pop_valid,
  output trd_pkg::item_t    pop_item
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  trd_pkg::item_t     mem_r [DEPTH];
  logic [PW-1:0]      wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]      rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]      cnt_r, cnt_nxt;

  assign full      = (cnt_r == CW'(DEPTH));
  assign pop_valid = (cnt_r != '0);
  assign pop_item  = mem_r[rd_ptr_r];

  // Pointers wrap at the depth; the count follows pushes and pops.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

/* hw/rtl/trd_back.sv */
// Back part: limit registers, span and status evaluation, and the output register.
`include "tls_record_deframer_unit_macros.svh"

module trd_back (
  input  logic              clk,
  input  logic              rst_n,
  trd_cfg_if.sink           cfg_chan,
  input  logic              q_valid,
  input  trd_pkg::item_t    q_item,
  output logic              q_pop,
  trd_out_if.source         out_chan
);

  trd_pkg::length_t max_plain_r, max_plain_nxt;
  trd_pkg::length_t max_cipher_r, max_cipher_nxt;

  logic             ovalid_r, ovalid_nxt;
  trd_pkg::byte_t   pbyte_r, pbyte_nxt;
  logic             pvalid_r, pvalid_nxt;
  logic             done_r, done_nxt;
  trd_pkg::status_t status_r, status_nxt;
  trd_pkg::byte_t   ctype_r, ctype_nxt;
  trd_pkg::length_t plen_r, plen_nxt;
  trd_pkg::count_t  span_r, span_nxt;
  logic             compl_r, compl_nxt;

  logic             load;
  logic             type_ok;
  logic             len_over;

  // Configuration writes are always taken; unknown indexes are dropped.
  assign cfg_chan.ready = 1'b1;

  always_comb begin
    max_plain_nxt  = max_plain_r;
    max_cipher_nxt = max_cipher_r;
    if (cfg_chan.valid) begin
      if (cfg_chan.index == trd_pkg::CFG_MAX_PLAIN) begin
        max_plain_nxt = cfg_chan.data;
      end else if (cfg_chan.index == trd_pkg::CFG_MAX_CIPHER) begin
        max_cipher_nxt = cfg_chan.data;
      end
    end
  end

  // A queued transaction moves into the output register when it is free or draining.
  assign load  = q_valid && (!ovalid_r || out_chan.ready);
  assign q_pop = load;

  // Span report and final status of the queued byte.
  always_comb begin
    type_ok  = (q_item.rtype inside {[trd_pkg::TYPE_LOW:trd_pkg::TYPE_HIGH]});
    len_over = (q_item.rtype == trd_pkg::TYPE_APPDATA) ? (q_item.dlen > max_cipher_r)
                                                       : (q_item.dlen > max_plain_r);
    span_nxt  = '0;
    compl_nxt = 1'b0;
    if ((q_item.seen >= trd_pkg::HDR_BYTES) && (q_item.dlen <= max_cipher_r)) begin
      span_nxt  = trd_pkg::HDR_BYTES + {1'b0, q_item.dlen};
      compl_nxt = (q_item.seen >= span_nxt);
    end
    status_nxt = trd_pkg::ST_OK;
    ctype_nxt  = '0;
    plen_nxt   = '0;
    if (q_item.last) begin
      if (q_item.seen < trd_pkg::HDR_BYTES) begin
        status_nxt = trd_pkg::ST_LENGTH;
      end else if (!type_ok) begin
        status_nxt = trd_pkg::ST_BAD_TYPE;
      end else if (len_over) begin
        status_nxt = trd_pkg::ST_OVERFLOW;
      end else if ((q_item.seen - trd_pkg::HDR_BYTES) != {1'b0, q_item.dlen}) begin
        status_nxt = trd_pkg::ST_LENGTH;
      end else begin
        ctype_nxt = q_item.rtype;
        plen_nxt  = q_item.dlen;
      end
    end
    pbyte_nxt  = q_item.pv ? q_item.data : '0;
    pvalid_nxt = q_item.pv;
    done_nxt   = q_item.last;
  end

  // Output valid flag.
  always_comb begin
    ovalid_nxt = ovalid_r;
    if (load) begin
      ovalid_nxt = 1'b1;
    end else if (out_chan.ready) begin
      ovalid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_plain_r  <= trd_pkg::MAX_PLAIN_RST;
      max_cipher_r <= trd_pkg::MAX_CIPHER_RST;
      ovalid_r     <= 1'b0;
    end else begin
      max_plain_r  <= max_plain_nxt;
      max_cipher_r <= max_cipher_nxt;
      ovalid_r     <= ovalid_nxt;
    end
  end

  // Result payload register.
  always_ff @(posedge clk) begin
    if (load) begin
      pbyte_r  <= pbyte_nxt;
      pvalid_r <= pvalid_nxt;
      done_r   <= done_nxt;
      status_r <= status_nxt;
      ctype_r  <= ctype_nxt;
      plen_r   <= plen_nxt;
      span_r   <= span_nxt;
      compl_r  <= compl_nxt;
    end
  end

  assign out_chan.valid          = ovalid_r;
  assign out_chan.payload_byte   = pbyte_r;
  assign out_chan.payload_valid  = pvalid_r;
  assign out_chan.record_done    = done_r;
  assign out_chan.status         = status_r;
  assign out_chan.content_type   = ctype_r;
  assign out_chan.payload_length = plen_r;
  assign out_chan.record_span    = span_r;
  assign out_chan.span_complete  = compl_r;

  // A failing status only appears on the last byte of a buffer.
  `TRD_ASSERT_SAME(a_status_on_done, clk, rst_n, ovalid_r && (status_r != trd_pkg::ST_OK), done_r)
  // A completed span always comes with a nonzero span.
  `TRD_ASSERT_SAME(a_complete_has_span, clk, rst_n, ovalid_r && compl_r, span_r != '0)
  // A held result stays put until it is taken.
  `TRD_ASSERT_NEXT(a_hold_result, clk, rst_n, ovalid_r && !out_chan.ready, ovalid_r && $stable(span_r))

endmodule

/* hw/rtl/tls_record_deframer_unit.sv */
// Record deframer top level: an accepted byte passes through the queue and the back output register to the result.
// One byte is accepted per cycle, sustained, while results are taken every cycle.
// The queue and the back output register are each registered; the front part is combinational.
// Reset is synchronous and active low: the byte counter, the header fields, the queue
// and the output valid clear, and the length limits return to 16384 and 16640.
module tls_record_deframer_unit #(
  parameter int QUEUE_DEPTH = trd_pkg::QUEUE_DEPTH
) (
  input  logic       clk,
  input  logic       rst_n,
  trd_in_if.sink     in_chan,
  trd_out_if.source  out_chan,
  trd_cfg_if.sink    cfg_chan
);

  logic            q_full;
  logic            q_push;
  logic            q_pop;
  logic            q_valid;
  trd_pkg::item_t  q_push_item;
  trd_pkg::item_t  q_pop_item;

  // Header tracking and byte classification.
  trd_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_chan),
    .q_full  (q_full),
    .q_push  (q_push),
    .q_item  (q_push_item)
  );

  // Decoupling queue.
  trd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (q_push_item),
    .full      (q_full),
    .pop       (q_pop),
    .pop_valid (q_valid),
    .pop_item  (q_pop_item)
  );

  // Status evaluation and output register.
  trd_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_chan (cfg_chan),
    .q_valid  (q_valid),
    .q_item   (q_pop_item),
    .q_pop    (q_pop),
    .out_chan (out_chan)
  );

endmodule
